[rtl/core/hepe_pkg.sv]
// Package for the HTML-escaping percent encoder: character types, run buffer
// types, item kinds and the unreserved-set and hex-digit functions.
// No dependencies.
`timescale 1ns / 1ps

package hepe_pkg;

	localparam int CHAR_W  = 7;
	localparam int RUN_MAX = 10;
	localparam int LEN_W   = $clog2(RUN_MAX + 1);

	typedef logic [CHAR_W-1:0] char_t;
	typedef char_t [RUN_MAX-1:0] run_t;
	typedef logic [LEN_W-1:0] len_t;

	// How a source byte expands.
	typedef enum logic [2:0] {
		KIND_UNRES,
		KIND_PCT,
		KIND_LT,
		KIND_GT,
		KIND_AMP,
		KIND_QUOT
	} kind_t;

	// One complete run handed to the output serializer.
	typedef struct packed {
		run_t chars;
		len_t len;
	} run_load_t;

	localparam char_t CH_PCT = 7'h25;
	localparam char_t CH_2   = 7'h32;
	localparam char_t CH_3   = 7'h33;
	localparam char_t CH_6   = 7'h36;
	localparam char_t CH_B   = 7'h42;
	localparam char_t CH_A_L = 7'h61;
	localparam char_t CH_G_L = 7'h67;
	localparam char_t CH_L_L = 7'h6C;
	localparam char_t CH_M_L = 7'h6D;
	localparam char_t CH_O_L = 7'h6F;
	localparam char_t CH_P_L = 7'h70;
	localparam char_t CH_Q_L = 7'h71;
	localparam char_t CH_T_L = 7'h74;
	localparam char_t CH_U_L = 7'h75;

	localparam logic [7:0] B_LT   = 8'h3C;
	localparam logic [7:0] B_GT   = 8'h3E;
	localparam logic [7:0] B_AMP  = 8'h26;
	localparam logic [7:0] B_QUOT = 8'h22;

	function automatic logic is_unreserved(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) ||
			c == 8'h2D || c == 8'h5F || c == 8'h2E || c == 8'h7E;
	endfunction

	function automatic char_t hex_char(input logic [3:0] d);
		char_t r;
		if (d < 4'd10) begin
			r = CHAR_W'(7'h30 + {3'd0, d});
		end else begin
			r = CHAR_W'(7'h37 + {3'd0, d});
		end
		return r;
	endfunction

endpackage

[rtl/core/hepe_serializer.sv]
// Output serializer of the HTML-escaping percent encoder: holds one run and
// shifts it out one character per transaction. Depends on hepe_pkg.
`timescale 1ns / 1ps

module hepe_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	input  hepe_pkg::run_load_t load_run,
	output logic               load_ready,
	output logic               out_valid,
	input  logic               out_stall,
	output hepe_pkg::char_t    out_char,
	output logic               run_end
);
	import hepe_pkg::*;

	run_t chars_q;
	len_t left_q;
	logic take;

	assign out_valid  = (left_q != '0);
	assign out_char   = chars_q[0];
	assign run_end    = (left_q == LEN_W'(1));
	assign take       = out_valid && !out_stall;
	// A new run may enter as the last character of the current one leaves.
	assign load_ready = !out_valid || (take && run_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load_valid && load_ready) begin
			left_q <= load_run.len;
		end else if (take) begin
			left_q <= left_q - LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			chars_q <= load_run.chars;
		end else if (take) begin
			chars_q <= chars_q >> CHAR_W;
		end
	end

endmodule

[rtl/core/html_escape_percent_encoder.sv]
// Top level of the HTML-escaping percent encoder: three pipeline stages and
// the output serializer. Depends on hepe_pkg and hepe_serializer.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------
//   source  | src_valid | src_stall | src_byte
//   output  | out_valid | out_stall | out_char, run_end
//
// A byte passes three register stages (capture, classify, run build) and then
// leaves as one character per cycle while out_stall is low. Runs are 1, 3, 8,
// 9 or 10 characters long, and the single-character output serializer sets
// the sustained byte rate.
// Reset clears the stage valid bits and the serializer count only.
// A stall on the output backs up stage by stage; src_stall rises only once
// all three stages and the serializer hold work.
`timescale 1ns / 1ps

module html_escape_percent_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_valid,
	output logic            src_stall,
	input  logic [7:0]      src_byte,
	output logic            out_valid,
	input  logic            out_stall,
	output hepe_pkg::char_t out_char,
	output logic            run_end
);
	import hepe_pkg::*;

	logic       valid_s1, valid_s2, valid_s3;
	logic       ready_s1, ready_s2, ready_s3;
	logic [7:0] byte_s1;
	kind_t      kind_s2;
	char_t      ch_s2, hi_s2, lo_s2;
	run_load_t  run_s3;
	run_load_t  run_next;
	kind_t      kind_next;
	logic       ser_ready;

	assign ready_s3  = !valid_s3 || ser_ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign src_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= src_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: capture.
	always_ff @(posedge clk) begin
		if (ready_s1) byte_s1 <= src_byte;
	end

	// Stage 2: classify the byte and form its hex digits.
	always_comb begin
		case (byte_s1)
			B_LT:    kind_next = KIND_LT;
			B_GT:    kind_next = KIND_GT;
			B_AMP:   kind_next = KIND_AMP;
			B_QUOT:  kind_next = KIND_QUOT;
			default: kind_next = is_unreserved(byte_s1) ? KIND_UNRES : KIND_PCT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			kind_s2 <= kind_next;
			ch_s2   <= byte_s1[CHAR_W-1:0];
			hi_s2   <= hex_char(byte_s1[7:4]);
			lo_s2   <= hex_char(byte_s1[3:0]);
		end
	end

	// Stage 3: lay out the whole run. Every entity starts with the
	// encoded ampersand and ends with the encoded semicolon.
	always_comb begin
		run_next.chars = '0;
		run_next.len   = LEN_W'(1);
		case (kind_s2)
			KIND_UNRES: begin
				run_next.chars[0] = ch_s2;
			end
			KIND_PCT: begin
				run_next.chars[0] = CH_PCT;
				run_next.chars[1] = hi_s2;
				run_next.chars[2] = lo_s2;
				run_next.len      = LEN_W'(3);
			end
			KIND_LT, KIND_GT: begin
				run_next.chars[0] = CH_PCT;
				run_next.chars[1] = CH_2;
				run_next.chars[2] = CH_6;
				run_next.chars[3] = (kind_s2 == KIND_LT) ? CH_L_L : CH_G_L;
				run_next.chars[4] = CH_T_L;
				run_next.chars[5] = CH_PCT;
				run_next.chars[6] = CH_3;
				run_next.chars[7] = CH_B;
				run_next.len      = LEN_W'(8);
			end
			KIND_AMP: begin
				run_next.chars[0] = CH_PCT;
				run_next.chars[1] = CH_2;
				run_next.chars[2] = CH_6;
				run_next.chars[3] = CH_A_L;
				run_next.chars[4] = CH_M_L;
				run_next.chars[5] = CH_P_L;
				run_next.chars[6] = CH_PCT;
				run_next.chars[7] = CH_3;
				run_next.chars[8] = CH_B;
				run_next.len      = LEN_W'(9);
			end
			KIND_QUOT: begin
				run_next.chars[0] = CH_PCT;
				run_next.chars[1] = CH_2;
				run_next.chars[2] = CH_6;
				run_next.chars[3] = CH_Q_L;
				run_next.chars[4] = CH_U_L;
				run_next.chars[5] = CH_O_L;
				run_next.chars[6] = CH_T_L;
				run_next.chars[7] = CH_PCT;
				run_next.chars[8] = CH_3;
				run_next.chars[9] = CH_B;
				run_next.len      = LEN_W'(10);
			end
			default: begin
				run_next.chars[0] = ch_s2;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ready_s3) run_s3 <= run_next;
	end

	hepe_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s3),
		.load_run   (run_s3),
		.load_ready (ser_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.run_end    (run_end)
	);

	// A run that has not ended keeps the output busy.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !run_end) |=> out_valid)
		else $error("output run broke off before its last character");

	// The source side is held back only when the first stage is occupied.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1)
		else $error("source stalled with an empty first stage");

	// A new run is loaded only into an empty serializer or over a finishing one.
	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && ser_ready) |-> (!out_valid || (run_end && !out_stall)))
		else $error("run loaded over characters still pending");

endmodule

[tb/sv/tb_html_escape_percent_encoder.sv]
// Self-checking testbench for html_escape_percent_encoder: drives source bytes,
// predicts each escaped and percent-encoded character run, checks the output.
// Depends on hepe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_html_escape_percent_encoder;

	import hepe_pkg::*;

	localparam int STALL_PCT   = 31;
	localparam int HOLD_CYCLES = 60;
	localparam int IDLE_LIMIT  = 2000;
	localparam int RANDOM_N    = 300;
	localparam int PRINT_MAX   = 50;

	// Keeps the characters still owed by the encoder, oldest first.
	class run_scoreboard;
		typedef struct packed {
			char_t ch;
			logic  last;
		} coded_char_t;

		coded_char_t owed[$];
		coded_char_t run_q[$];
		int unsigned failures;
		string hex_digits = "0123456789ABCDEF";

		function bit passes_plain(logic [7:0] c);
			return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
				(c >= "0" && c <= "9") ||
				c == "-" || c == "_" || c == "." || c == "~";
		endfunction

		function string entity_of(logic [7:0] b);
			case (b)
				B_LT:    return "&lt;";
				B_GT:    return "&gt;";
				B_AMP:   return "&amp;";
				B_QUOT:  return "&quot;";
				default: return "";
			endcase
		endfunction

		function void append_coded(logic [7:0] c);
			coded_char_t e;
			e.last = 1'b0;
			if (passes_plain(c)) begin
				e.ch = c[6:0];
				run_q.push_back(e);
			end else begin
				e.ch = CH_PCT;
				run_q.push_back(e);
				e.ch = char_t'(hex_digits[c[7:4]]);
				run_q.push_back(e);
				e.ch = char_t'(hex_digits[c[3:0]]);
				run_q.push_back(e);
			end
		endfunction

		// Called once per accepted source transaction.
		function void note_source(logic [7:0] b);
			string ent;
			ent = entity_of(b);
			run_q.delete();
			if (ent.len() == 0) begin
				append_coded(b);
			end else begin
				for (int i = 0; i < ent.len(); i++) begin
					append_coded(ent[i]);
				end
			end
			run_q[run_q.size()-1].last = 1'b1;
			foreach (run_q[i]) begin
				owed.push_back(run_q[i]);
			end
		endfunction

		task report(string msg);
			if (failures < PRINT_MAX) begin
				$display("mismatch at %0t ns: %s", $time, msg);
			end
			failures++;
		endtask

		// Called once per accepted output transaction.
		task check_result(char_t ch, logic last);
			coded_char_t e;
			if (owed.size() == 0) begin
				report($sformatf("unexpected char 0x%02h run_end %0b", ch, last));
			end else begin
				e = owed.pop_front();
				if (e.ch !== ch) begin
					report($sformatf("out_char 0x%02h, want 0x%02h", ch, e.ch));
				end
				if (e.last !== last) begin
					report($sformatf("run_end %0b, want %0b on char 0x%02h",
						last, e.last, e.ch));
				end
			end
		endtask

		task close_out();
			if (owed.size() != 0) begin
				report($sformatf("%0d chars never arrived", owed.size()));
			end
		endtask
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  src_valid = 1'b0;
	logic  src_stall;
	logic  [7:0] src_byte = 8'h00;
	logic  out_valid;
	logic  out_stall = 1'b0;
	char_t out_char;
	logic  run_end;

	run_scoreboard sb = new();
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int unsigned idle_cycles = 0;

	html_escape_percent_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_byte  (src_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.run_end   (run_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99) < STALL_PCT) begin
			src_valid <= 1'b0;
			src_byte  <= 8'($urandom);
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_byte  <= b;
		do begin
			@(posedge clk);
		end while (src_stall);
		sb.note_source(b);
	endtask

	// Stops offering and waits until every owed character has come out.
	task automatic drain();
		src_valid <= 1'b0;
		while (sb.owed.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 20) begin
			case ($urandom_range(3))
				0:       return B_LT;
				1:       return B_GT;
				2:       return B_AMP;
				default: return B_QUOT;
			endcase
		end else if (r < 45) begin
			case ($urandom_range(4))
				0:       return 8'($urandom_range("Z", "A"));
				1:       return 8'($urandom_range("z", "a"));
				2:       return 8'($urandom_range("9", "0"));
				default: return 8'("-_.~" >> (8 * $urandom_range(3)));
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	// Output side: random stalls, plus a long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !steady && $urandom_range(99) < STALL_PCT;
			end
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_result(out_char, run_end);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && !src_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] directed [$];
		directed = '{8'h00, 8'hFF, 8'h80, 8'h7F, B_LT, B_GT, B_AMP, B_QUOT,
			"A", "Z", "a", "z", "0", "9", "-", "_", ".", "~",
			8'h20, 8'h2F, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h3A};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_byte(directed[i]);
		end
		drain();

		for (int i = 0; i < RANDOM_N; i++) begin
			// Long hold-offs on the output while bytes keep coming in.
			if (i == 0 || i == 250) begin
				hold_req = 1'b1;
			end
			steady = (i >= 100 && i < 180);
			if (i == 150) begin
				drain();
			end
			send_byte(pick_byte());
		end
		steady = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		sb.close_out();
		if (sb.failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
